### rtl/core/sequence_composition_counter_defines.svh
`ifndef SEQUENCE_COMPOSITION_COUNTER_DEFINES_SVH
`define SEQUENCE_COMPOSITION_COUNTER_DEFINES_SVH

// condition a implies condition c on the same edge
`define SCC_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("scc check failed");

// condition a implies condition c on the next edge
`define SCC_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("scc check failed");

`endif

### rtl/core/scc_pkg.sv
`timescale 1ns / 1ps

package scc_pkg;

	localparam int HIST_ENTRIES = 256;
	localparam int SYM_BITS     = 8;
	localparam int MODE_BITS    = 2;
	localparam int OUT_BITS     = 32;
	localparam int PAIR_ENTRIES = 16;
	localparam int PAIR_BITS    = 4;
	localparam int NUM_BASES    = 4;
	localparam int Q_DEPTH      = 4;
	localparam int Q_PTR_BITS   = 2;
	localparam int RES_DEPTH    = 4;
	localparam int RES_PTR_BITS = 2;

	localparam logic [SYM_BITS-1:0] CHAR_A = 8'h41;
	localparam logic [SYM_BITS-1:0] CHAR_C = 8'h43;
	localparam logic [SYM_BITS-1:0] CHAR_G = 8'h47;
	localparam logic [SYM_BITS-1:0] CHAR_T = 8'h54;
	localparam logic [SYM_BITS-1:0] CHAR_U = 8'h55;
	localparam logic [SYM_BITS-1:0] CHAR_N = 8'h4E;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_CLEAR   = 2'd0,
		MODE_SYMBOL  = 2'd1,
		MODE_RD_HIST = 2'd2,
		MODE_RD_PAIR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		BASE_A = 2'd0,
		BASE_C = 2'd1,
		BASE_G = 2'd2,
		BASE_T = 2'd3
	} base_t;

	typedef struct packed {
		logic  hit;
		base_t code;
	} base_class_t;

	// classified operation handed from front to back
	typedef struct packed {
		mode_t                 kind;
		logic [SYM_BITS-1:0]   addr;
		logic                  cnt_hit;
		base_t                 cnt_sel;
		logic                  pair_hit;
		logic [PAIR_BITS-1:0]  pair_sel;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} op_beat_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] entry_count;
		logic [OUT_BITS-1:0] count_a;
		logic [OUT_BITS-1:0] count_c;
		logic [OUT_BITS-1:0] count_g;
		logic [OUT_BITS-1:0] count_t;
		logic [OUT_BITS-1:0] seq_length;
	} result_t;

	// strict dna alphabet, no U
	function automatic base_class_t base_code(input logic [SYM_BITS-1:0] s);
		base_class_t r;
		r.hit  = 1'b1;
		r.code = BASE_A;
		case (s)
			CHAR_A: r.code = BASE_A;
			CHAR_C: r.code = BASE_C;
			CHAR_G: r.code = BASE_G;
			CHAR_T: r.code = BASE_T;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/scc_if.sv
`timescale 1ns / 1ps

interface scc_in_if
	import scc_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [MODE_BITS-1:0] mode;
	logic [SYM_BITS-1:0]  symbol;
	logic [SYM_BITS-1:0]  index;

	modport source (output valid, output mode, output symbol, output index, input ready);
	modport sink (input valid, input mode, input symbol, input index, output ready);
endinterface

interface scc_out_if
	import scc_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] entry_count;
	logic [OUT_BITS-1:0] count_a;
	logic [OUT_BITS-1:0] count_c;
	logic [OUT_BITS-1:0] count_g;
	logic [OUT_BITS-1:0] count_t;
	logic [OUT_BITS-1:0] seq_length;

	modport source (output valid, output entry_count, output count_a, output count_c,
		output count_g, output count_t, output seq_length, input ready);
	modport sink (input valid, input entry_count, input count_a, input count_c,
		input count_g, input count_t, input seq_length, output ready);
endinterface

interface scc_cfg_if;
	logic valid;
	logic ready;
	logic dinuc_enable;

	modport source (output valid, output dinuc_enable, input ready);
	modport sink (input valid, input dinuc_enable, output ready);
endinterface

### rtl/core/sequence_composition_counter.sv
// sequence composition counter
// req channel: one beat per operation (mode, symbol, index). mode clear zeroes
// every count, mode symbol counts one sequence byte, the two read modes ask for
// a byte histogram entry or a pair entry.
// rsp channel: one beat per read, carrying the entry plus the four base counts
// and the length; clear and symbol beats give no rsp beat.
// cfg channel: writes dinuc_enable, always ready; write only while idle.
// throughput: one req beat per cycle while rsp takes results; the histogram
// read-modify-write in the back pipeline forwards the last written value for
// repeated symbols. read path: a req beat reaches rsp through the op queue,
// the histogram read stage and the update stage into the result queue.
// stall: a stalled rsp fills the 4-deep result queue, then the back stops
// pulling ops and the 4-deep op queue drops req.ready; nothing is lost.
// reset: all counts zero, previous symbol N, dinuc_enable off, no clearing pass
// since the histogram carries a valid bit per entry.
`timescale 1ns / 1ps

module sequence_composition_counter
	import scc_pkg::*;
#(
	parameter int COUNT_BITS = 32
)
(
	input  logic      clk,
	input  logic      arst_n,
	scc_in_if.sink    req,
	scc_out_if.source rsp,
	scc_cfg_if.sink   cfg
);

	// config register
	logic     dinuc_q;

	// front to queue, queue to back
	op_beat_t push;
	op_beat_t head;
	logic     q_full;
	logic     pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dinuc_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			dinuc_q <= cfg.dinuc_enable;
		end
	end

	// front: takes req beats, classifies bases and pairs, tracks previous symbol
	scc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.dinuc_enable (dinuc_q),
		.q_full       (q_full),
		.push         (push)
	);

	// short queue so front and back stall independently
	scc_op_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// back: histogram memory, counters and result queue
	scc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

### rtl/core/scc_front.sv
`timescale 1ns / 1ps

module scc_front
	import scc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	scc_in_if.sink   req,
	input  logic     dinuc_enable,
	input  logic     q_full,
	output op_beat_t push
);

	logic                accept;
	mode_t               mode;
	base_class_t         cur_cls;
	base_class_t         prev_cls;
	logic [SYM_BITS-1:0] prev_sym_q;

	assign req.ready = !q_full;

	always_comb begin
		accept   = req.valid && req.ready;
		mode     = mode_t'(req.mode);
		cur_cls  = base_code(req.symbol);
		prev_cls = base_code(prev_sym_q);

		push.valid       = accept;
		push.op.kind     = mode;
		push.op.addr     = req.index;
		// U is counted as T in the base counts only
		push.op.cnt_hit  = cur_cls.hit || (req.symbol == CHAR_U);
		push.op.cnt_sel  = cur_cls.hit ? cur_cls.code : BASE_T;
		push.op.pair_hit = 1'b0;
		push.op.pair_sel = req.index[PAIR_BITS-1:0];
		case (mode)
			MODE_SYMBOL: begin
				push.op.addr     = req.symbol;
				push.op.pair_hit = dinuc_enable && prev_cls.hit && cur_cls.hit;
				push.op.pair_sel = {prev_cls.code, cur_cls.code};
			end
			MODE_RD_PAIR: begin
				push.op.pair_hit = (req.index[SYM_BITS-1:PAIR_BITS] == '0);
			end
			default: begin
			end
		endcase
	end

	// previous symbol follows every symbol beat, clear puts it back to N
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sym_q <= CHAR_N;
		end else if (accept) begin
			case (mode)
				MODE_SYMBOL: prev_sym_q <= req.symbol;
				MODE_CLEAR:  prev_sym_q <= CHAR_N;
				default:     prev_sym_q <= prev_sym_q;
			endcase
		end
	end

endmodule

### rtl/core/scc_op_queue.sv
`timescale 1ns / 1ps
`include "sequence_composition_counter_defines.svh"

module scc_op_queue
	import scc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  op_beat_t push,
	output logic     full,
	output op_beat_t head,
	input  logic     pop
);

	op_t                   slot_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_PTR_BITS:0]   cnt_q;
	logic                  do_push;
	logic                  do_pop;

	always_comb begin
		full       = (cnt_q == (Q_PTR_BITS+1)'(Q_DEPTH));
		head.valid = (cnt_q != '0);
		head.op    = slot_q[rd_ptr_q];
		do_push    = push.valid && !full;
		do_pop     = pop && head.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.op;
		end
	end

	// the front gates its ready on full, so no beat is ever dropped here
	`SCC_ASSERT_NOW(a_no_push_when_full, clk, arst_n, push.valid, !full)

endmodule

### rtl/core/scc_back.sv
`timescale 1ns / 1ps
`include "sequence_composition_counter_defines.svh"

module scc_back
	import scc_pkg::*;
#(
	parameter int COUNT_BITS = 32
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  op_beat_t  head,
	output logic      pop,
	scc_out_if.source rsp
);

	// stage 1: histogram read issue, stage 2: read-modify-write and result
	logic                  valid_s1;
	op_t                   op_s1;
	logic                  valid_s2;
	op_t                   op_s2;

	logic [COUNT_BITS-1:0] hist_mem [HIST_ENTRIES];
	logic [COUNT_BITS-1:0] hist_rd_s2;
	logic                  hist_vld_s2;
	logic [HIST_ENTRIES-1:0] hist_vld_q;

	logic                  fwd_hit_q;
	logic                  fwd_clr_q;
	logic [SYM_BITS-1:0]   fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	logic [COUNT_BITS-1:0] base_cnt_q [NUM_BASES];
	logic [COUNT_BITS-1:0] pair_cnt_q [PAIR_ENTRIES];
	logic [COUNT_BITS-1:0] len_q;

	result_t               res_q [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] res_wr_q;
	logic [RES_PTR_BITS-1:0] res_rd_q;
	logic [RES_PTR_BITS:0] res_cnt_q;
	logic [RES_PTR_BITS:0] budget;

	logic                  rd_s1;
	logic                  rd_s2;
	logic                  do_sym;
	logic                  do_clr;
	logic                  res_push;
	logic                  res_pop;
	logic [COUNT_BITS-1:0] cur_hist;
	logic [COUNT_BITS-1:0] hist_new;
	logic [COUNT_BITS-1:0] entry;
	result_t               res_new;
	result_t               res_head;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS+OUT_BITS-1:0] ext;
		ext = {{OUT_BITS{1'b0}}, v};
		return ext[OUT_BITS-1:0];
	endfunction

	always_comb begin
		rd_s1  = valid_s1 && (op_s1.kind == MODE_RD_HIST || op_s1.kind == MODE_RD_PAIR);
		rd_s2  = valid_s2 && (op_s2.kind == MODE_RD_HIST || op_s2.kind == MODE_RD_PAIR);
		// reserve a result slot for every read still in flight
		budget = res_cnt_q + (RES_PTR_BITS+1)'(rd_s1) + (RES_PTR_BITS+1)'(rd_s2);
		pop    = head.valid && (budget < (RES_PTR_BITS+1)'(RES_DEPTH));
		do_sym = valid_s2 && (op_s2.kind == MODE_SYMBOL);
		do_clr = valid_s2 && (op_s2.kind == MODE_CLEAR);

		// the op just ahead in stage 2 wrote after this op's read was issued
		if (fwd_hit_q && fwd_addr_q == op_s2.addr) begin
			cur_hist = fwd_data_q;
		end else if (fwd_clr_q || !hist_vld_s2) begin
			cur_hist = '0;
		end else begin
			cur_hist = hist_rd_s2;
		end
		hist_new = sat_inc(cur_hist);

		if (op_s2.kind == MODE_RD_HIST) begin
			entry = cur_hist;
		end else if (op_s2.pair_hit) begin
			entry = pair_cnt_q[op_s2.pair_sel];
		end else begin
			entry = '0;
		end

		res_new.entry_count = to_out(entry);
		res_new.count_a     = to_out(base_cnt_q[BASE_A]);
		res_new.count_c     = to_out(base_cnt_q[BASE_C]);
		res_new.count_g     = to_out(base_cnt_q[BASE_G]);
		res_new.count_t     = to_out(base_cnt_q[BASE_T]);
		res_new.seq_length  = to_out(len_q);
		res_push            = rd_s2;

		res_head        = res_q[res_rd_q];
		rsp.valid       = (res_cnt_q != '0);
		rsp.entry_count = res_head.entry_count;
		rsp.count_a     = res_head.count_a;
		rsp.count_c     = res_head.count_c;
		rsp.count_g     = res_head.count_g;
		rsp.count_t     = res_head.count_t;
		rsp.seq_length  = res_head.seq_length;
		res_pop         = rsp.valid && rsp.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			fwd_hit_q  <= 1'b0;
			fwd_clr_q  <= 1'b0;
			hist_vld_q <= '0;
			len_q      <= '0;
			for (int i = 0; i < NUM_BASES; i++) begin
				base_cnt_q[i] <= '0;
			end
			for (int i = 0; i < PAIR_ENTRIES; i++) begin
				pair_cnt_q[i] <= '0;
			end
		end else begin
			valid_s1  <= pop;
			valid_s2  <= valid_s1;
			fwd_hit_q <= do_sym;
			fwd_clr_q <= do_clr;
			if (do_clr) begin
				hist_vld_q <= '0;
				len_q      <= '0;
				for (int i = 0; i < NUM_BASES; i++) begin
					base_cnt_q[i] <= '0;
				end
				for (int i = 0; i < PAIR_ENTRIES; i++) begin
					pair_cnt_q[i] <= '0;
				end
			end else if (do_sym) begin
				hist_vld_q[op_s2.addr] <= 1'b1;
				len_q                  <= sat_inc(len_q);
				if (op_s2.cnt_hit) begin
					base_cnt_q[op_s2.cnt_sel] <= sat_inc(base_cnt_q[op_s2.cnt_sel]);
				end
				if (op_s2.pair_hit) begin
					pair_cnt_q[op_s2.pair_sel] <= sat_inc(pair_cnt_q[op_s2.pair_sel]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s1      <= head.op;
		op_s2      <= op_s1;
		fwd_addr_q <= op_s2.addr;
		fwd_data_q <= hist_new;
		if (valid_s1) begin
			hist_rd_s2  <= hist_mem[op_s1.addr];
			hist_vld_s2 <= hist_vld_q[op_s1.addr];
		end
		if (do_sym) begin
			hist_mem[op_s2.addr] <= hist_new;
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			case ({res_push, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 1'b1;
				2'b01:   res_cnt_q <= res_cnt_q - 1'b1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_new;
		end
	end

	`SCC_ASSERT_NOW(a_res_room, clk, arst_n, res_push, res_cnt_q != (RES_PTR_BITS+1)'(RES_DEPTH))
	`SCC_ASSERT_NEXT(a_clear_zeroes_len, clk, arst_n, do_clr, len_q == '0)
	`SCC_ASSERT_NEXT(a_symbol_counts, clk, arst_n, do_sym, len_q != '0)

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import scc_pkg::*;

	localparam int HOLD_CYCLES    = 200;   // long result back-pressure stretch
	localparam int SETTLE_CYCLES  = 10;    // lets the pipeline drain, with margin
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
	localparam int IDLE_PCT       = 32;
	localparam int MAX_PRINTS     = 50;

	localparam logic [SYM_BITS-1:0] CHAR_DASH  = 8'h2D;
	localparam logic [SYM_BITS-1:0] CHAR_LOW_A = 8'h61;

	// one request beat as the sequencer sees it
	typedef struct {
		mode_t               mode;
		logic [SYM_BITS-1:0] sym;
		logic [SYM_BITS-1:0] idx;
	} scc_op_t;

	logic clk = 1'b0;
	logic arst_n;

	scc_in_if  req ();
	scc_out_if rsp ();
	scc_cfg_if cfg ();

	sequence_composition_counter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ops waiting to go out on req, head is the beat currently offered
	scc_op_t op_q[$];
	// read replies the composition model says must come back, oldest first
	result_t read_replies_q[$];

	// composition model state
	logic [OUT_BITS-1:0] hist_cnt[HIST_ENTRIES];
	logic [OUT_BITS-1:0] pair_cnt[PAIR_ENTRIES];
	logic [OUT_BITS-1:0] base_cnt[NUM_BASES];
	logic [OUT_BITS-1:0] len_cnt;
	logic [SYM_BITS-1:0] last_sym;
	logic                pairs_on;

	int   fail_count   = 0;
	int   quiet_cycles = 0;
	logic no_idle      = 1'b0;   // set for the stretch with no gaps on either side
	logic pressure_go  = 1'b0;   // starts the long rsp hold-off
	logic rsp_hold     = 1'b0;

	task automatic report_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [OUT_BITS-1:0] got,
			input logic [OUT_BITS-1:0] want);
		if (got !== want)
			report_fail($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// counters stick at all ones
	function automatic logic [OUT_BITS-1:0] bump(input logic [OUT_BITS-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// pair table code of a strict dna letter, -1 for anything else (U included)
	function automatic int dna_code(input logic [SYM_BITS-1:0] s);
		case (s)
			CHAR_A:  return 0;
			CHAR_C:  return 1;
			CHAR_G:  return 2;
			CHAR_T:  return 3;
			default: return -1;
		endcase
	endfunction

	task automatic wipe_counts();
		foreach (hist_cnt[i]) hist_cnt[i] = '0;
		foreach (pair_cnt[i]) pair_cnt[i] = '0;
		foreach (base_cnt[i]) base_cnt[i] = '0;
		len_cnt  = '0;
		last_sym = CHAR_N;
	endtask

	// apply one accepted op to the model, queue the reply for reads
	task automatic tally_op(input scc_op_t op);
		result_t r;
		int      f;
		int      s;
		case (op.mode)
			MODE_CLEAR: begin
				wipe_counts();
			end
			MODE_SYMBOL: begin
				case (op.sym)
					CHAR_A:         base_cnt[BASE_A] = bump(base_cnt[BASE_A]);
					CHAR_C:         base_cnt[BASE_C] = bump(base_cnt[BASE_C]);
					CHAR_G:         base_cnt[BASE_G] = bump(base_cnt[BASE_G]);
					CHAR_T, CHAR_U: base_cnt[BASE_T] = bump(base_cnt[BASE_T]);
					default: ;
				endcase
				hist_cnt[op.sym] = bump(hist_cnt[op.sym]);
				len_cnt = bump(len_cnt);
				// pair needs both letters in ACGT, so N and dash never pair
				if (pairs_on) begin
					f = dna_code(last_sym);
					s = dna_code(op.sym);
					if (f >= 0 && s >= 0)
						pair_cnt[f * 4 + s] = bump(pair_cnt[f * 4 + s]);
				end
				// previous letter tracks even with pair counting off
				last_sym = op.sym;
			end
			default: begin
				r.entry_count = '0;
				if (op.mode == MODE_RD_HIST)
					r.entry_count = hist_cnt[op.idx];
				else if (op.idx < PAIR_ENTRIES)
					r.entry_count = pair_cnt[op.idx[PAIR_BITS-1:0]];
				r.count_a    = base_cnt[BASE_A];
				r.count_c    = base_cnt[BASE_C];
				r.count_g    = base_cnt[BASE_G];
				r.count_t    = base_cnt[BASE_T];
				r.seq_length = len_cnt;
				read_replies_q.push_back(r);
			end
		endcase
	endtask

	task automatic push_op(input mode_t m, input logic [SYM_BITS-1:0] s,
			input logic [SYM_BITS-1:0] i);
		scc_op_t op;
		op.mode = m;
		op.sym  = s;
		op.idx  = i;
		op_q.push_back(op);
	endtask

	// mostly bases, some U, N and dash, now and then any byte
	function automatic logic [SYM_BITS-1:0] pick_letter();
		case ($urandom_range(11))
			0, 1:    return CHAR_A;
			2, 3:    return CHAR_C;
			4, 5:    return CHAR_G;
			6, 7:    return CHAR_T;
			8:       return CHAR_U;
			9:       return CHAR_N;
			10:      return CHAR_DASH;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic scc_op_t random_op(input int read_pct);
		scc_op_t op;
		int      roll;
		roll   = $urandom_range(99);
		op.sym = 8'($urandom);
		op.idx = 8'($urandom);
		if (roll < 2) begin
			op.mode = MODE_CLEAR;
		end else if (roll < 2 + read_pct) begin
			if ($urandom_range(1) == 1) begin
				op.mode = MODE_RD_PAIR;
				// mostly real pair entries, sometimes out of range
				if ($urandom_range(4) != 0)
					op.idx = 8'($urandom_range(PAIR_ENTRIES - 1));
			end else begin
				op.mode = MODE_RD_HIST;
				if ($urandom_range(1) == 1)
					op.idx = pick_letter();
			end
		end else begin
			op.mode = MODE_SYMBOL;
			op.sym  = pick_letter();
		end
		return op;
	endfunction

	// wait until every op is out and every read reply has come back
	task automatic wait_idle();
		while (op_q.size() != 0 || read_replies_q.size() != 0)
			@(posedge clk);
		// clear and symbol beats leave no reply, let them drain too
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dinuc(input logic en);
		@(posedge clk);
		cfg.valid        <= 1'b1;
		cfg.dinuc_enable <= en;
		do
			@(posedge clk);
		while (!cfg.ready);
		pairs_on = en;
		cfg.valid <= 1'b0;
	endtask

	// req driver: offer the head of op_q, hold it steady while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready)
				tally_op(op_q.pop_front());
			if (!req.valid || req.ready) begin
				if (op_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					req.valid  <= 1'b1;
					req.mode   <= op_q[0].mode;
					req.symbol <= op_q[0].sym;
					req.index  <= op_q[0].idx;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// rsp monitor: every reply beat against the oldest expected read
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (read_replies_q.size() == 0) begin
					report_fail("reply beat with no read outstanding");
				end else begin
					want = read_replies_q.pop_front();
					check_field("entry_count", rsp.entry_count, want.entry_count);
					check_field("count_a", rsp.count_a, want.count_a);
					check_field("count_c", rsp.count_c, want.count_c);
					check_field("count_g", rsp.count_g, want.count_g);
					check_field("count_t", rsp.count_t, want.count_t);
					check_field("seq_length", rsp.seq_length, want.seq_length);
				end
			end
			rsp.ready <= !rsp_hold && (no_idle || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// long hold-off on rsp so both internal queues fill and req backs up
	initial begin
		@(posedge pressure_go);
		@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	// watchdog: too long with no beat on any channel means a hang
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg.valid        <= 1'b0;
		cfg.dinuc_enable <= 1'b0;
		wipe_counts();
		pairs_on = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// everything reads zero straight out of reset
		push_op(MODE_RD_HIST, 8'h00, 8'h00);
		push_op(MODE_RD_PAIR, 8'hFF, 8'h00);
		wait_idle();

		// directed: pairs on, every base, U, N, dash, lowercase, byte extremes
		write_dinuc(1'b1);
		push_op(MODE_SYMBOL, CHAR_A, 8'h00);
		push_op(MODE_SYMBOL, CHAR_C, 8'hFF);
		push_op(MODE_SYMBOL, CHAR_G, 8'h00);
		push_op(MODE_SYMBOL, CHAR_T, 8'hFF);
		push_op(MODE_SYMBOL, CHAR_U, 8'h00);     // counts as T but never pairs
		push_op(MODE_SYMBOL, CHAR_N, 8'h00);
		push_op(MODE_SYMBOL, CHAR_DASH, 8'h00);
		push_op(MODE_SYMBOL, CHAR_LOW_A, 8'h00); // lowercase hits histogram and length only
		push_op(MODE_SYMBOL, 8'hFF, 8'h00);
		push_op(MODE_SYMBOL, 8'h00, 8'h00);
		push_op(MODE_SYMBOL, CHAR_A, 8'h00);
		push_op(MODE_SYMBOL, CHAR_A, 8'h00);     // back to back, same entry
		push_op(MODE_SYMBOL, CHAR_G, 8'h00);
		push_op(MODE_RD_PAIR, 8'h00, 8'd0);
		push_op(MODE_RD_PAIR, 8'h00, 8'd6);
		push_op(MODE_RD_PAIR, 8'h00, 8'd16);     // first out of range pair index
		push_op(MODE_RD_PAIR, 8'h00, 8'hFF);
		push_op(MODE_RD_HIST, 8'h00, CHAR_T);
		push_op(MODE_RD_HIST, 8'h00, 8'hFF);
		push_op(MODE_RD_HIST, 8'h00, 8'h00);
		push_op(MODE_CLEAR, 8'hFF, 8'hFF);
		push_op(MODE_RD_HIST, 8'h00, CHAR_A);
		push_op(MODE_SYMBOL, CHAR_C, 8'h00);     // previous letter is N again
		push_op(MODE_RD_PAIR, 8'h00, 8'd1);
		wait_idle();

		// random, pair counting off
		write_dinuc(1'b0);
		repeat (250) op_q.push_back(random_op(30));
		wait_idle();

		// random, pair counting on, no gaps on either side
		write_dinuc(1'b1);
		no_idle <= 1'b1;
		repeat (200) op_q.push_back(random_op(30));
		wait_idle();
		no_idle <= 1'b0;

		// read heavy while rsp is held off for a long stretch
		pressure_go <= 1'b1;
		repeat (150) op_q.push_back(random_op(70));
		wait_idle();

		// random, pair counting off again
		write_dinuc(1'b0);
		repeat (200) op_q.push_back(random_op(30));
		wait_idle();

		if (read_replies_q.size() != 0)
			report_fail($sformatf("%0d reads never answered", read_replies_q.size()));
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
